// ===== hw/rtl/bdh_pkg.sv =====
// ----------------------------------------------------------------------------
// bdh_pkg
// shared types and constants for the button debounce and hold detector
// ----------------------------------------------------------------------------
package bdh_pkg;

    // field widths
    localparam int LevelBits   = 2;
    localparam int LevelIdxW   = 1;
    localparam int TickW       = 16;
    localparam int CfgDataW    = 16;
    localparam int CfgAddrW    = 1;

    // register reset values and defaults
    localparam int DefaultButtons = 2;
    localparam logic [TickW-1:0] DefaultBounce = 16'd20;
    localparam logic [TickW-1:0] DefaultHold   = 16'd1000;
    localparam logic [TickW-1:0] TickMax       = 16'hFFFF;

    // register indexes
    localparam logic [CfgAddrW-1:0] RegBounceTicks = 1'd0;
    localparam logic [CfgAddrW-1:0] RegHoldTicks   = 1'd1;

    typedef enum logic [1:0] {
        PH_RELEASED        = 2'd0,
        PH_PRESS_PENDING   = 2'd1,
        PH_PRESSED         = 2'd2,
        PH_RELEASE_PENDING = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_PRESS = 2'd1,
        EV_HOLD  = 2'd2
    } event_t;

    // result of one tick step
    typedef struct packed {
        phase_t machine_state;
        logic   event_button;
        event_t event_kind;
    } result_t;

endpackage

// ===== hw/rtl/bdh_core.sv =====
// ----------------------------------------------------------------------------
// bdh_core
// debounce state machine, tick counter and event latch, one step per tick
// ----------------------------------------------------------------------------
module bdh_core #(
    parameter int NUM_BUTTONS = bdh_pkg::DefaultButtons
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [bdh_pkg::LevelBits-1:0]  button_levels,
    input  logic                           clear_event,
    input  logic [bdh_pkg::TickW-1:0]      bounce_ticks,
    input  logic [bdh_pkg::TickW-1:0]      hold_ticks,
    output bdh_pkg::result_t               result
);

    localparam int BtnW  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int ScanN = (NUM_BUTTONS < bdh_pkg::LevelBits) ? NUM_BUTTONS
                                                              : bdh_pkg::LevelBits;

    bdh_pkg::phase_t             phase_reg, phase_next;
    logic [bdh_pkg::TickW-1:0]   elapsed_reg, elapsed_next;
    logic [BtnW-1:0]             tracked_reg, tracked_next;
    bdh_pkg::event_t             latched_reg, latched_next;
    logic [BtnW-1:0]             lbutton_reg, lbutton_next;

    logic [bdh_pkg::TickW-1:0]   elapsed_inc;
    logic                        any_pressed;
    logic [BtnW-1:0]             pick;
    logic                        tracked_pressed;
    logic                        bounce_done;
    logic                        hold_done;

    // saturating tick count, lowest active button, level of tracked button
    always_comb
    begin
        elapsed_inc = (elapsed_reg != bdh_pkg::TickMax) ? elapsed_reg + 1'b1 : elapsed_reg;
        bounce_done = (elapsed_inc >= bounce_ticks);
        hold_done   = (elapsed_inc >= hold_ticks);
        any_pressed = 1'b0;
        pick        = '0;
        for (int i = ScanN - 1; i >= 0; i--)
        begin
            if (!button_levels[i])
            begin
                any_pressed = 1'b1;
                pick        = BtnW'(i);
            end
        end
        if (32'(tracked_reg) < bdh_pkg::LevelBits)
            tracked_pressed = !button_levels[tracked_reg[bdh_pkg::LevelIdxW-1:0]];
        else
            tracked_pressed = 1'b0;
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            bdh_pkg::PH_RELEASED:
            begin
                if (any_pressed)
                    phase_next = bdh_pkg::PH_PRESS_PENDING;
            end
            bdh_pkg::PH_PRESS_PENDING:
            begin
                if (bounce_done)
                    phase_next = tracked_pressed ? bdh_pkg::PH_PRESSED
                                                 : bdh_pkg::PH_RELEASED;
            end
            bdh_pkg::PH_PRESSED:
            begin
                if (!tracked_pressed)
                    phase_next = bdh_pkg::PH_RELEASE_PENDING;
            end
            bdh_pkg::PH_RELEASE_PENDING:
            begin
                if (bounce_done)
                    phase_next = tracked_pressed ? bdh_pkg::PH_PRESSED
                                                 : bdh_pkg::PH_RELEASED;
            end
            default:
                phase_next = bdh_pkg::PH_RELEASED;
        endcase
    end

    // counter, tracked button and event latch
    always_comb
    begin
        elapsed_next = elapsed_inc;
        tracked_next = tracked_reg;
        latched_next = clear_event ? bdh_pkg::EV_NONE : latched_reg;
        lbutton_next = clear_event ? '0 : lbutton_reg;
        case (phase_reg)
            bdh_pkg::PH_RELEASED:
            begin
                if (any_pressed)
                begin
                    tracked_next = pick;
                    elapsed_next = '0;
                end
            end
            bdh_pkg::PH_PRESS_PENDING:
            begin
                if (bounce_done && tracked_pressed)
                    elapsed_next = '0;
            end
            bdh_pkg::PH_PRESSED:
            begin
                if (hold_done)
                begin
                    latched_next = bdh_pkg::EV_HOLD;
                    lbutton_next = tracked_reg;
                    elapsed_next = '0;
                end
                if (!tracked_pressed)
                    elapsed_next = '0;
            end
            bdh_pkg::PH_RELEASE_PENDING:
            begin
                if (bounce_done && !tracked_pressed)
                begin
                    latched_next = bdh_pkg::EV_PRESS;
                    lbutton_next = tracked_reg;
                end
            end
            default:
                elapsed_next = elapsed_inc;
        endcase
    end

    // outputs show the state after the step
    always_comb
    begin
        result.machine_state = phase_next;
        result.event_kind    = latched_next;
        result.event_button  = lbutton_next[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= bdh_pkg::PH_RELEASED;
            elapsed_reg <= '0;
            tracked_reg <= '0;
            latched_reg <= bdh_pkg::EV_NONE;
            lbutton_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            tracked_reg <= tracked_next;
            latched_reg <= latched_next;
            lbutton_reg <= lbutton_next;
        end
    end

`ifndef SYNTHESIS
    // a press has to pass the pending phase first
    a_no_skip_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == bdh_pkg::PH_RELEASED)
        |=> (phase_reg != bdh_pkg::PH_PRESSED && phase_reg != bdh_pkg::PH_RELEASE_PENDING))
        else $error("released phase jumped past press pending");

    // state holds while no tick is stepped
    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(phase_reg) && $stable(elapsed_reg) && $stable(latched_reg)))
        else $error("state changed without a tick");

    // counter restarts, counts by one or sits at saturation
    a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (elapsed_reg == '0
                  || elapsed_reg == $past(elapsed_reg) + 1'b1
                  || (elapsed_reg == bdh_pkg::TickMax && $past(elapsed_reg) == bdh_pkg::TickMax)))
        else $error("tick counter moved by more than one");

    // a press event is only latched on leaving release pending
    a_press_source: assert property (@(posedge clk) disable iff (!rst_n)
        (step && latched_next == bdh_pkg::EV_PRESS && latched_reg != bdh_pkg::EV_PRESS)
        |-> (phase_reg == bdh_pkg::PH_RELEASE_PENDING && phase_next == bdh_pkg::PH_RELEASED))
        else $error("press event latched outside a confirmed release");
`endif

endmodule

// ===== hw/rtl/button_debounce_hold_detector.sv =====
// ----------------------------------------------------------------------------
// button_debounce_hold_detector
// debounces active-low buttons and reports press and long-press events
// ----------------------------------------------------------------------------
// Every request on the input stream is one millisecond tick carrying the raw
// button levels and a clear flag; every tick gives exactly one result with the
// latched event, its button and the debounce state after that tick. The block
// takes one tick per clock cycle while the consumer keeps up: the tick lands
// in an input register, the whole debounce step (saturating tick counter,
// lowest-button pick, bounce and hold compares) runs in one pass of logic in
// bdh_core, and the answer is held in the result register. Both stages advance
// together whenever the result register is empty or being taken, so a full
// stream rate is kept while the consumer keeps up. bounce_ticks and hold_ticks
// are written through the cfg port; the user must write them only while the
// stream is idle, which the block itself does not enforce.
module button_debounce_hold_detector #(
    parameter int NUM_BUTTONS = bdh_pkg::DefaultButtons
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // tick input: [1:0] button_levels, [2] clear_event, [7:3] zero
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,

    // result output: [1:0] event_kind, [2] event_button, [4:3] machine_state,
    // [7:5] zero
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,

    // register write port
    input  logic                          cfg_wr_en,
    input  logic [bdh_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [bdh_pkg::CfgDataW-1:0]  cfg_wdata
);

    // config registers
    logic [bdh_pkg::TickW-1:0]     bounce_reg;
    logic [bdh_pkg::TickW-1:0]     hold_reg;

    // input stage
    logic                          in_valid_reg;
    logic [bdh_pkg::LevelBits-1:0] levels_reg;
    logic                          clear_reg;

    // result stage
    logic                          out_valid_reg;
    bdh_pkg::result_t              out_reg;

    bdh_pkg::result_t              step_result;
    logic                          advance;

    // a tick moves into the result register when that slot frees up
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounce_reg <= bdh_pkg::DefaultBounce;
            hold_reg   <= bdh_pkg::DefaultHold;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                bdh_pkg::RegBounceTicks: bounce_reg <= cfg_wdata;
                bdh_pkg::RegHoldTicks:   hold_reg   <= cfg_wdata;
                default:                 bounce_reg <= bounce_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            levels_reg <= s_axis_tdata[bdh_pkg::LevelBits-1:0];
            clear_reg  <= s_axis_tdata[bdh_pkg::LevelBits];
        end
    end

    bdh_core #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .button_levels (levels_reg),
        .clear_event   (clear_reg),
        .bounce_ticks  (bounce_reg),
        .hold_ticks    (hold_reg),
        .result        (step_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= step_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.machine_state, out_reg.event_button,
                            out_reg.event_kind};

`ifndef SYNTHESIS
    // a waiting result is never overwritten
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // a held tick blocks the input only while the output stalls
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // every stepped tick shows up as a result on the next cycle
    a_step_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("stepped tick produced no result");
`endif

endmodule
